@@ sv/swhsr_pkg.sv @@
`timescale 1ns / 1ps
// Package for the single-wire humidity sensor reader.
// Holds the register map, reset values and the types shared by the reader's modules; no dependencies.
package swhsr_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_START_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RELEASE      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_DELAY = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_LIMIT   = 2'd3;

    localparam logic [15:0] START_LOW_RESET    = 16'd18000;
    localparam logic [7:0]  RELEASE_RESET      = 8'd20;
    localparam logic [7:0]  SAMPLE_DELAY_RESET = 8'd30;
    localparam logic [7:0]  WAIT_LIMIT_RESET   = 8'd100;

    localparam int unsigned FRAME_BYTES_DEFAULT = 5;
    localparam int unsigned BITS_PER_BYTE       = 8;

    // Input word kinds carried on the slave tuser bit.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  sample_delay_ticks;
        logic [7:0]  wait_limit_ticks;
    } cfg_t;

    typedef struct packed {
        logic       busy_res;
        logic       timed_out;
        logic       transfer_done;
        logic [2:0] byte_number;
        logic [7:0] data_byte;
        logic       drive_low;
        logic       byte_valid;
    } result_t;

endpackage

@@ sv/single_wire_humidity_sensor_reader.sv @@
`timescale 1ns / 1ps
// Top level of the single-wire humidity sensor reader: config registers, sequencer, result register.
// Depends on swhsr_pkg, swhsr_core and swhsr_out_reg.
//
//   Channel   Direction  Handshake            Contents
//   s_*       in         s_tvalid/s_tready    tuser: command; tdata: line_level
//   m_*       out        m_tvalid/m_tready    tuser: byte_valid; tdata: result fields
//   cfg_*     in         cfg_we               cfg_index selects register, cfg_data value
//
// The sequencer state and the result register are both updated at the edge where an input word is
// accepted, so one word per cycle is sustained while the sink takes every result.
// The result of a word appears on the master side in the cycle after it is accepted.
// s_tready is low only while the result register holds a word the sink has not taken;
// a stall on the master side therefore stalls the slave side with no word lost.
// Reset returns the sequencer to idle and loads all configuration registers with
// their default values.
module single_wire_humidity_sensor_reader #(
    parameter int unsigned FRAME_BYTES = swhsr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic                               s_tuser,   // command
    input  logic [7:0]                         s_tdata,   // line_level, zero fill
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic                               m_tuser,   // byte_valid
    // drive_low, data_byte, byte_number, transfer_done, timed_out, busy_res, zero fill
    output logic [15:0]                        m_tdata,
    input  logic                               cfg_we,
    input  logic [swhsr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [swhsr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    swhsr_pkg::cfg_t    cfg_reg;
    swhsr_pkg::result_t core_result;
    swhsr_pkg::result_t out_result;
    logic               out_free;
    logic               in_fire;

    // Config writes land unchecked; the user must issue them only while no word is in flight.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks    <= swhsr_pkg::START_LOW_RESET;
            cfg_reg.release_ticks      <= swhsr_pkg::RELEASE_RESET;
            cfg_reg.sample_delay_ticks <= swhsr_pkg::SAMPLE_DELAY_RESET;
            cfg_reg.wait_limit_ticks   <= swhsr_pkg::WAIT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                swhsr_pkg::REG_START_LOW:    cfg_reg.start_low_ticks    <= cfg_data;
                swhsr_pkg::REG_RELEASE:      cfg_reg.release_ticks      <= cfg_data[7:0];
                swhsr_pkg::REG_SAMPLE_DELAY: cfg_reg.sample_delay_ticks <= cfg_data[7:0];
                swhsr_pkg::REG_WAIT_LIMIT:   cfg_reg.wait_limit_ticks   <= cfg_data[7:0];
                default:                     cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign s_tready = out_free;
    assign in_fire  = s_tvalid && out_free;

    swhsr_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (in_fire),
        .command    (s_tuser),
        .line_level (s_tdata[0]),
        .cfg        (cfg_reg),
        .result     (core_result)
    );

    swhsr_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .load_data (core_result),
        .free      (out_free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tuser = out_result.byte_valid;
    assign m_tdata = {1'b0,
                      out_result.busy_res,
                      out_result.timed_out,
                      out_result.transfer_done,
                      out_result.byte_number,
                      out_result.data_byte,
                      out_result.drive_low};

endmodule

@@ sv/swhsr_core.sv @@
`timescale 1ns / 1ps
// Protocol sequencer: phase, tick counter and byte assembly, with the result of each word.
// Depends on swhsr_pkg.
module swhsr_core #(
    parameter int unsigned FRAME_BYTES = swhsr_pkg::FRAME_BYTES_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  logic                   command,
    input  logic                   line_level,
    input  swhsr_pkg::cfg_t        cfg,
    output swhsr_pkg::result_t     result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_LOW,
        PH_RELEASE,
        PH_RESP_LOW,
        PH_RESP_HIGH,
        PH_RESP_END,
        PH_BIT_HIGH,
        PH_SAMPLE,
        PH_BIT_LOW
    } phase_t;

    localparam logic [2:0] LAST_BIT  = 3'(swhsr_pkg::BITS_PER_BYTE - 1);
    localparam logic [2:0] LAST_BYTE = 3'(FRAME_BYTES - 1);

    phase_t      phase_reg, phase_next;
    logic [15:0] tick_reg, tick_next;
    logic [2:0]  bit_reg, bit_next;
    logic [2:0]  byte_reg, byte_next;
    logic [7:0]  shift_reg, shift_next;

    logic [15:0] tick_inc;
    logic [7:0]  shifted;
    logic        want_high;
    logic        frame_done;

    always_comb
    begin
        tick_inc   = (tick_reg == 16'hFFFF) ? tick_reg : tick_reg + 16'd1;
        shifted    = {shift_reg[6:0], line_level};
        want_high  = (phase_reg == PH_RESP_HIGH) || (phase_reg == PH_BIT_HIGH);
        frame_done = (byte_reg >= LAST_BYTE);

        phase_next = phase_reg;
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;

        result = '0;

        if (command == swhsr_pkg::CMD_START)
        begin
            phase_next = PH_START_LOW;
            tick_next  = '0;
            bit_next   = '0;
            byte_next  = '0;
            shift_next = '0;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_START_LOW:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.start_low_ticks)
                    begin
                        phase_next = PH_RELEASE;
                        tick_next  = '0;
                    end
                end
                PH_RELEASE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= {8'd0, cfg.release_ticks})
                    begin
                        phase_next = PH_RESP_LOW;
                        tick_next  = '0;
                    end
                end
                PH_RESP_LOW, PH_RESP_HIGH, PH_RESP_END, PH_BIT_HIGH, PH_BIT_LOW:
                begin
                    if (line_level == want_high)
                    begin
                        tick_next = '0;
                        case (phase_reg)
                            PH_RESP_LOW:  phase_next = PH_RESP_HIGH;
                            PH_RESP_HIGH: phase_next = PH_RESP_END;
                            PH_BIT_HIGH:  phase_next = PH_SAMPLE;
                            default:      phase_next = PH_BIT_HIGH;
                        endcase
                    end
                    else if (tick_inc > {8'd0, cfg.wait_limit_ticks})
                    begin
                        // Expected edge never came: abandon the frame.
                        result.timed_out = 1'b1;
                        phase_next       = PH_IDLE;
                        tick_next        = '0;
                    end
                    else
                    begin
                        tick_next = tick_inc;
                    end
                end
                PH_SAMPLE:
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= {8'd0, cfg.sample_delay_ticks})
                    begin
                        tick_next = '0;
                        if (bit_reg >= LAST_BIT)
                        begin
                            result.byte_valid    = 1'b1;
                            result.data_byte     = shifted;
                            result.byte_number   = byte_reg;
                            result.transfer_done = frame_done;
                            bit_next             = '0;
                            shift_next           = '0;
                            if (frame_done)
                            begin
                                byte_next  = '0;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                byte_next  = byte_reg + 3'd1;
                                phase_next = PH_BIT_LOW;
                            end
                        end
                        else
                        begin
                            shift_next = shifted;
                            bit_next   = bit_reg + 3'd1;
                            phase_next = PH_BIT_LOW;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        result.drive_low = (phase_next == PH_START_LOW);
        result.busy_res  = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            shift_reg <= '0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
        end
    end

endmodule

@@ sv/swhsr_out_reg.sv @@
`timescale 1ns / 1ps
// Result register of the reader: holds one result word until the sink takes it.
// Depends on swhsr_pkg.
module swhsr_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  swhsr_pkg::result_t load_data,
    output logic               free,
    output logic               out_valid,
    input  logic               out_ready,
    output swhsr_pkg::result_t out_data
);

    logic               valid_reg;
    swhsr_pkg::result_t data_reg;

    // The register can take a new word when empty or when its word leaves this cycle.
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

endmodule

@@ sv/swhsr_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the single-wire humidity sensor reader, bound to the top level.
// Depends only on the top-level ports.
module swhsr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic        m_tuser,
    input logic [15:0] m_tdata
);

    // A start word yields a word that drives the line low and reports busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser |=> m_tvalid && m_tdata[0] && m_tdata[14])
        else $error("start word did not produce drive_low and busy");

    // The last byte of a frame is a valid byte and ends the reading.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[12] |-> m_tuser && !m_tdata[14] && !m_tdata[0])
        else $error("transfer_done without byte or with busy");

    // A timeout ends the reading and carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[13] |-> !m_tuser && !m_tdata[14] && m_tdata[8:1] == 8'd0)
        else $error("timeout with byte or busy");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed under stall");

endmodule

bind single_wire_humidity_sensor_reader swhsr_checker u_swhsr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tuser  (m_tuser),
    .m_tdata  (m_tdata)
);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for single_wire_humidity_sensor_reader: a directed table, then frames
// from a modeled sensor, checked against a cycle-free predictor. Depends on swhsr_pkg and the RTL.
module testbench;

    // The run is stopped here if the result stream stalls for good. A correct run, even with
    // every word held up by the longest sink stall, ends well before it.
    localparam int unsigned CYCLE_LIMIT   = 400_000;
    localparam int unsigned PHASE_COUNT   = 9;
    localparam int unsigned PHASE_BUDGET  = 220;
    localparam int unsigned EXTREME_WORDS = 64;
    localparam int unsigned FRAME_BITS    =
        swhsr_pkg::FRAME_BYTES_DEFAULT * swhsr_pkg::BITS_PER_BYTE;

    // Sequencer states of the predictor, in protocol order.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PULL_LOW,
        ST_RELEASED,
        ST_ACK_LOW,
        ST_ACK_HIGH,
        ST_ACK_END,
        ST_BIT_RISE,
        ST_BIT_SAMPLE,
        ST_BIT_FALL
    } seq_state_t;

    // A directed row either sends one word or lets the results drain and clears every register.
    typedef enum logic {
        ROW_WORD,
        ROW_ZERO_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t          kind;
        logic               cmd;
        logic               lvl;
        logic               pinned;
        swhsr_pkg::result_t want;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic        s_tuser = swhsr_pkg::CMD_TICK;            // command
    logic [7:0]  s_tdata = 8'd0;                           // line_level, zero fill
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic        m_tuser;                                  // byte_valid
    // drive_low, data_byte, byte_number, transfer_done, timed_out, busy_res, zero fill
    logic [15:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [swhsr_pkg::CFG_INDEX_W-1:0] cfg_index = swhsr_pkg::REG_START_LOW;
    logic [swhsr_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // Predictor state: its own copy of the registers and of the sequencer.
    swhsr_pkg::cfg_t shadow_cfg;
    seq_state_t  st;
    logic [15:0] dwell;
    logic [2:0]  bit_idx;
    logic [2:0]  byte_idx;
    logic [7:0]  shreg;

    swhsr_pkg::result_t pending_readouts[$];
    stim_row_t          stim_rows[$];
    swhsr_pkg::result_t seen;
    swhsr_pkg::result_t want_r;

    // When set, neither side inserts idle cycles.
    logic        calm = 1'b0;

    // Sensor frames stop sending once this many words have gone out.
    int unsigned word_cap = 0;

    int unsigned mismatch_count = 0;
    int unsigned words_fed = 0;
    int unsigned readouts_checked = 0;
    int unsigned bytes_seen = 0;
    int unsigned frames_done = 0;
    int unsigned timeouts_seen = 0;
    int unsigned cycles_run = 0;

    single_wire_humidity_sensor_reader i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Hard stop in case the result stream never drains.
    initial
    begin : watchdog
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $display("testbench: done, errors");
        $finish;
    end

    // Saturating tick count, shared by every timed state.
    function automatic void count_dwell();
        if (dwell != 16'hFFFF)
            dwell = dwell + 16'd1;
    endfunction

    // Advances the predicted sequencer by one word and returns the readout it must produce.
    function automatic swhsr_pkg::result_t predict_reading(logic cmd, logic lvl);
        swhsr_pkg::result_t r;
        logic               wanted;
        r = '0;
        if (cmd == swhsr_pkg::CMD_START)
        begin
            // A start always begins a fresh pull-low, whatever was in progress.
            st = ST_PULL_LOW;
            dwell = 16'd0;
            bit_idx = 3'd0;
            byte_idx = 3'd0;
            shreg = 8'd0;
        end
        else
        begin
            case (st)
                ST_PULL_LOW:
                begin
                    count_dwell();
                    if (dwell >= shadow_cfg.start_low_ticks)
                    begin
                        st = ST_RELEASED;
                        dwell = 16'd0;
                    end
                end
                ST_RELEASED:
                begin
                    count_dwell();
                    if (dwell >= {8'd0, shadow_cfg.release_ticks})
                    begin
                        st = ST_ACK_LOW;
                        dwell = 16'd0;
                    end
                end
                ST_ACK_LOW, ST_ACK_HIGH, ST_ACK_END, ST_BIT_RISE, ST_BIT_FALL:
                begin
                    // Edge waits: the wanted level ends the wait on the very tick it shows up,
                    // every other tick counts toward the timeout.
                    wanted = (st == ST_ACK_HIGH || st == ST_BIT_RISE);
                    if (lvl == wanted)
                    begin
                        dwell = 16'd0;
                        case (st)
                            ST_ACK_LOW:  st = ST_ACK_HIGH;
                            ST_ACK_HIGH: st = ST_ACK_END;
                            ST_BIT_RISE: st = ST_BIT_SAMPLE;
                            default:     st = ST_BIT_RISE;
                        endcase
                    end
                    else
                    begin
                        count_dwell();
                        if (dwell > {8'd0, shadow_cfg.wait_limit_ticks})
                        begin
                            r.timed_out = 1'b1;
                            st = ST_IDLE;
                            dwell = 16'd0;
                        end
                    end
                end
                ST_BIT_SAMPLE:
                begin
                    count_dwell();
                    if (dwell >= {8'd0, shadow_cfg.sample_delay_ticks})
                    begin
                        dwell = 16'd0;
                        shreg = {shreg[6:0], lvl};
                        if (bit_idx == 3'(swhsr_pkg::BITS_PER_BYTE - 1))
                        begin
                            r.byte_valid = 1'b1;
                            r.data_byte = shreg;
                            r.byte_number = byte_idx;
                            r.transfer_done =
                                (byte_idx >= 3'(swhsr_pkg::FRAME_BYTES_DEFAULT - 1));
                            bit_idx = 3'd0;
                            shreg = 8'd0;
                            byte_idx = byte_idx + 3'd1;
                            if (r.transfer_done)
                            begin
                                // Last byte: no wait for the sensor's closing pulse.
                                byte_idx = 3'd0;
                                st = ST_IDLE;
                            end
                            else
                            begin
                                st = ST_BIT_FALL;
                            end
                        end
                        else
                        begin
                            bit_idx = bit_idx + 3'd1;
                            st = ST_BIT_FALL;
                        end
                    end
                end
                default:
                begin
                    // Ticks while idle change nothing.
                    st = ST_IDLE;
                end
            endcase
        end
        r.drive_low = (st == ST_PULL_LOW);
        r.busy_res = (st != ST_IDLE);
        return r;
    endfunction

    // Readout with only the status bits set, for rows typed in by hand.
    function automatic swhsr_pkg::result_t status_word(logic drive, logic busy, logic tout);
        swhsr_pkg::result_t r;
        r = '0;
        r.drive_low = drive;
        r.busy_res = busy;
        r.timed_out = tout;
        return r;
    endfunction

    function automatic void add_row(row_kind_t kind, logic cmd, logic lvl, logic pinned,
                                    swhsr_pkg::result_t want);
        stim_rows.push_back('{kind, cmd, lvl, pinned, want});
    endfunction

    // An 8-bit register value with random junk above it, which the reader must mask off.
    function automatic logic [15:0] junk_high(int unsigned val);
        return {8'($urandom), 8'(val)};
    endfunction

    function automatic void check_field(string name, logic [7:0] expv, logic [7:0] gotv);
        if (expv !== gotv)
        begin
            $error("readout %0d: %s expected %0d, got %0d", readouts_checked, name, expv, gotv);
            mismatch_count++;
        end
    endfunction

    // Sends one word and records what it must produce. A pinned row supplies its own
    // expected readout; the predictor still steps so that its state stays in line.
    task automatic feed(logic cmd, logic lvl, logic pinned, swhsr_pkg::result_t pin);
        swhsr_pkg::result_t predicted;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, lvl};
        do
            @(posedge clk);
        while (!s_tready);
        words_fed++;
        predicted = predict_reading(cmd, lvl);
        pending_readouts.push_back(pinned ? pin : predicted);
    endtask

    // Optionally runs the reader into idle with levels that force a timeout, then holds the
    // sender off until every readout has come back.
    task automatic quiesce(logic to_idle);
        while (to_idle && st != ST_IDLE)
            feed(swhsr_pkg::CMD_TICK, (st == ST_ACK_HIGH || st == ST_BIT_RISE) ? 1'b0 : 1'b1,
                 1'b0, '0);
        s_tvalid <= 1'b0;
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [swhsr_pkg::CFG_INDEX_W-1:0] idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            swhsr_pkg::REG_START_LOW:    shadow_cfg.start_low_ticks = value;
            swhsr_pkg::REG_RELEASE:      shadow_cfg.release_ticks = value[7:0];
            swhsr_pkg::REG_SAMPLE_DELAY: shadow_cfg.sample_delay_ticks = value[7:0];
            default:                     shadow_cfg.wait_limit_ticks = value[7:0];
        endcase
    endtask

    // Writes all four registers back to back; the enable drops once after the last one.
    task automatic set_config(logic [15:0] sl, logic [15:0] rel, logic [15:0] sd,
                              logic [15:0] wl);
        write_reg(swhsr_pkg::REG_START_LOW, sl);
        write_reg(swhsr_pkg::REG_RELEASE, rel);
        write_reg(swhsr_pkg::REG_SAMPLE_DELAY, sd);
        write_reg(swhsr_pkg::REG_WAIT_LIMIT, wl);
        cfg_we <= 1'b0;
    endtask

    // Holds the line at one level for a number of ticks. Now and then the stretch is made
    // longer than the wait limit allows, which can end in a timeout.
    task automatic hold_level(logic lvl, int unsigned ticks);
        int unsigned n;
        n = ticks;
        if ($urandom_range(0, 63) == 0)
            n = n + shadow_cfg.wait_limit_ticks + 2;
        for (int unsigned k = 0; k < n && st != ST_IDLE && words_fed < word_cap; k++)
            feed(swhsr_pkg::CMD_TICK, lvl, 1'b0, '0);
    endtask

    // One reading as a well-behaved sensor would answer it: response low and high, then
    // forty bits whose high time decides the bit. Segment lengths stay inside the wait limit,
    // so most frames complete; stretched segments and the odd restart break some of them.
    // The frame is cut short once the word budget of the current stretch is spent.
    task automatic sensor_frame();
        int unsigned sdp;
        int unsigned span;
        int unsigned h;
        int unsigned lo;
        sdp = (shadow_cfg.sample_delay_ticks == 8'd0) ? 1 : shadow_cfg.sample_delay_ticks;
        span = (shadow_cfg.wait_limit_ticks < 8'd12) ? shadow_cfg.wait_limit_ticks : 12;
        feed(swhsr_pkg::CMD_START, $urandom_range(0, 1) != 0, 1'b0, '0);
        // The line is ignored while the reader pulls low and releases.
        while ((st == ST_PULL_LOW || st == ST_RELEASED) && words_fed < word_cap)
            feed(swhsr_pkg::CMD_TICK, $urandom_range(0, 1) != 0, 1'b0, '0);
        hold_level(1'b0, $urandom_range(1, span + 1));
        hold_level(1'b1, $urandom_range(1, span + 1));
        hold_level(1'b0, $urandom_range(1, span + 1));
        for (int unsigned b = 0; b < FRAME_BITS && st != ST_IDLE && words_fed < word_cap; b++)
        begin
            if ($urandom_range(0, 1) != 0)
            begin
                // A one: still high when the sample is taken.
                h = $urandom_range(sdp + 1, sdp + 1 + span);
                lo = $urandom_range(1, span + 1);
            end
            else
            begin
                // A zero: low again by the sample, low time stretched to cover it.
                h = $urandom_range(1, sdp);
                lo = sdp + 1 - h + $urandom_range(1, span + 1);
            end
            hold_level(1'b1, h);
            hold_level(1'b0, lo);
            if ($urandom_range(0, 299) == 0)
                feed(swhsr_pkg::CMD_START, $urandom_range(0, 1) != 0, 1'b0, '0);
        end
    endtask

    // Stall the result side in random bursts, except in the calm stretch at the end.
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                m_tready <= 1'b1;
            end
        end
    end

    // Every accepted readout is compared, field by field, with the oldest expectation.
    always @(posedge clk)
    begin
        if (m_tvalid === 1'b1 && m_tready === 1'b1)
        begin
            seen.byte_valid = m_tuser;
            seen.drive_low = m_tdata[0];
            seen.data_byte = m_tdata[8:1];
            seen.byte_number = m_tdata[11:9];
            seen.transfer_done = m_tdata[12];
            seen.timed_out = m_tdata[13];
            seen.busy_res = m_tdata[14];
            if (pending_readouts.size() == 0)
            begin
                $error("readout %0d arrived with nothing expected", readouts_checked);
                mismatch_count++;
            end
            else
            begin
                want_r = pending_readouts.pop_front();
                check_field("byte_valid", 8'(want_r.byte_valid), 8'(seen.byte_valid));
                check_field("drive_low", 8'(want_r.drive_low), 8'(seen.drive_low));
                check_field("data_byte", want_r.data_byte, seen.data_byte);
                check_field("byte_number", 8'(want_r.byte_number), 8'(seen.byte_number));
                check_field("transfer_done", 8'(want_r.transfer_done),
                            8'(seen.transfer_done));
                check_field("timed_out", 8'(want_r.timed_out), 8'(seen.timed_out));
                check_field("busy_res", 8'(want_r.busy_res), 8'(seen.busy_res));
            end
            readouts_checked++;
            if (seen.byte_valid)
                bytes_seen++;
            if (seen.transfer_done)
                frames_done++;
            if (seen.timed_out)
                timeouts_seen++;
        end
    end

    initial
    begin : stimulus
        stim_row_t row;

        shadow_cfg.start_low_ticks = swhsr_pkg::START_LOW_RESET;
        shadow_cfg.release_ticks = swhsr_pkg::RELEASE_RESET;
        shadow_cfg.sample_delay_ticks = swhsr_pkg::SAMPLE_DELAY_RESET;
        shadow_cfg.wait_limit_ticks = swhsr_pkg::WAIT_LIMIT_RESET;
        st = ST_IDLE;
        dwell = 16'd0;
        bit_idx = 3'd0;
        byte_idx = 3'd0;
        shreg = 8'd0;

        // With reset values: ticks while idle do nothing, a start pulls the line low,
        // and a second start while busy simply begins again.
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b1, status_word(1'b0, 1'b0, 1'b0));
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b1, status_word(1'b0, 1'b0, 1'b0));
        add_row(ROW_WORD, swhsr_pkg::CMD_START, 1'b1, 1'b1, status_word(1'b1, 1'b1, 1'b0));
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b1, status_word(1'b1, 1'b1, 1'b0));
        add_row(ROW_WORD, swhsr_pkg::CMD_START, 1'b0, 1'b1, status_word(1'b1, 1'b1, 1'b0));
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        // All registers zero: each timed state lasts one tick, and a wait times out on its
        // first tick without the wanted level.
        add_row(ROW_ZERO_CFG, swhsr_pkg::CMD_TICK, 1'b0, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_START, 1'b0, 1'b1, status_word(1'b1, 1'b1, 1'b0));
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b1, status_word(1'b0, 1'b1, 1'b0));
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        // Response low already on the line: the wait ends on its first tick.
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b1, status_word(1'b0, 1'b0, 1'b1));
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b1, status_word(1'b0, 1'b0, 1'b0));
        // A clean response followed by two bits, then a restart that drops the partial byte.
        add_row(ROW_WORD, swhsr_pkg::CMD_START, 1'b1, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b1, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_TICK, 1'b0, 1'b0, '0);
        add_row(ROW_WORD, swhsr_pkg::CMD_START, 1'b0, 1'b0, '0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        foreach (stim_rows[i])
        begin
            row = stim_rows[i];
            if (row.kind == ROW_ZERO_CFG)
            begin
                // The registers change in the middle of the default pull-low, once every readout has
                // come back; the start that follows then begins a fresh pull-low under the zero values.
                quiesce(1'b0);
                set_config(16'd0, 16'd0, 16'd0, 16'd0);
            end
            else
            begin
                feed(row.cmd, row.lvl, row.pinned, row.want);
            end
        end

        // Phase 0 starts a reading with every register at its top value (the 8-bit ones are
        // written as all ones and masked) and watches the start of the long pull-low. The
        // rest use short random timing; the new registers also cut a pull-low left running.
        // The last phase runs with no idling on either side.
        for (int unsigned ph = 0; ph < PHASE_COUNT; ph++)
        begin
            quiesce(1'b0);
            if (ph == 0)
                set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            else
                set_config(16'($urandom_range(0, 8)), junk_high($urandom_range(0, 6)),
                           junk_high($urandom_range(0, 6)), junk_high($urandom_range(0, 10)));
            calm = (ph == PHASE_COUNT - 1);
            if (ph != 0)
                quiesce(1'b1);
            word_cap = words_fed + ((ph == 0) ? EXTREME_WORDS : PHASE_BUDGET);
            while (words_fed < word_cap)
            begin
                if (ph == 0 || $urandom_range(0, 9) < 8)
                begin
                    sensor_frame();
                end
                else
                begin
                    // Line noise with an occasional start, landing anywhere in a reading.
                    repeat ($urandom_range(1, 30))
                        feed(($urandom_range(0, 15) == 0) ? swhsr_pkg::CMD_START
                                                          : swhsr_pkg::CMD_TICK,
                             $urandom_range(0, 1) != 0, 1'b0, '0);
                end
            end
        end

        // Everything sent: wait for the last readouts.
        quiesce(1'b0);

        $display("testbench: %0d words in, %0d readouts checked, %0d bytes, %0d frames,",
                 words_fed, readouts_checked, bytes_seen, frames_done);
        $display("testbench: %0d timeouts; register sets: reset, all zero, all ones, %0d random",
                 timeouts_seen, PHASE_COUNT - 1);
        if (mismatch_count == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/swhsr_pkg.sv
sv/swhsr_core.sv
sv/swhsr_out_reg.sv
sv/single_wire_humidity_sensor_reader.sv
sv/swhsr_checker.sv
sim/testbench.sv
